[rtl/core/gsmf_pkg.sv]
package gsmf_pkg;

    localparam int DIST_W     = 14;
    localparam int LIMIT_W    = 8;
    localparam int STREAK_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int MIN_COUNT  = 3;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

    localparam logic [DIST_W-1:0]  GATE_MIN_RST   = 14'd0;
    localparam logic [DIST_W-1:0]  GATE_MAX_RST   = 14'd16383;
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_MIN   = 2'd0,
        CFG_GATE_MAX   = 2'd1,
        CFG_FAIL_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

[rtl/core/gsmf_ifs.sv]
interface gsmf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [gsmf_pkg::DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

interface gsmf_result_if;
    logic                        valid;
    logic                        ready;
    logic                        median_valid;
    logic [gsmf_pkg::DIST_W-1:0] median_distance;

    modport source (output valid, output median_valid, output median_distance, input ready);
    modport sink   (input valid, input median_valid, input median_distance, output ready);
endinterface

[rtl/core/gated_sliding_median_filter_top.sv]
// channel   dir  payload                          beat taken when
// sample    in   distance[13:0]                   sample.valid & sample.ready
// result    out  median_valid, median_distance    result.valid & result.ready
// cfg       in   cfg_index[1:0], cfg_data[13:0]   cfg_we
//
// one beat accepted in idle; with n stored samples the median is found on one shared
// comparator (load a candidate, then rank it against n)
// samples that leave fewer than 3 stored skip the ranking and go straight to done
// the result sits in an output register, a new sample may enter while it waits
// rst_n clears the fsm, ring head, fill count, bad streak and config registers
// window contents are not cleared, only entries inside the fill count are used
module gated_sliding_median_filter_top #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gsmf_sample_if.sink                       sample,
    gsmf_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [gsmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int DW    = gsmf_pkg::DIST_W;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W+1)'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] MIN_C     = CNT_W'(gsmf_pkg::MIN_COUNT);

    // config
    logic [DW-1:0]                gate_min_reg;
    logic [DW-1:0]                gate_max_reg;
    logic [gsmf_pkg::LIMIT_W-1:0] fail_limit_reg;

    // window and control
    logic [DW-1:0]                 store_mem [WINDOW_DEPTH];
    gsmf_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [gsmf_pkg::STREAK_W-1:0] streak_reg, streak_next;

    // ranking datapath
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] rank_reg, rank_next;
    logic [DW-1:0]    cand_reg, cand_next;
    logic [DW-1:0]    rd_reg;
    logic             res_valid_reg, res_valid_next;
    logic [DW-1:0]    res_dist_reg, res_dist_next;

    // output stage
    logic             out_valid_reg, out_valid_next;
    logic             out_mv_reg, out_mv_next;
    logic [DW-1:0]    out_dist_reg, out_dist_next;

    logic                          in_fire;
    logic                          good;
    logic                          store_we;
    logic [gsmf_pkg::STREAK_W-1:0] streak_inc;
    logic [IDX_W-1:0]              k_sel;
    logic [IDX_W:0]                slot_sum;
    logic [IDX_W-1:0]              slot;
    logic                          lt;
    logic [IDX_W-1:0]              rank_sum;
    logic                          last_j;
    logic                          out_free;

    assign sample.ready    = (state_reg == gsmf_pkg::ST_IDLE);
    assign in_fire         = sample.valid && sample.ready;
    assign result.valid    = out_valid_reg;
    assign result.median_valid    = out_mv_reg;
    assign result.median_distance = out_dist_reg;
    assign out_free        = !out_valid_reg || result.ready;

    assign good = (sample.distance != '0) && (sample.distance >= gate_min_reg)
                  && (sample.distance <= gate_max_reg);
    assign streak_inc = (streak_reg < gsmf_pkg::STREAK_MAX)
                        ? streak_reg + 1'b1 : streak_reg;

    // ring slot of the k-th newest sample, addressed from the next-state indices so rd_reg holds it when used
    assign k_sel    = (state_next == gsmf_pkg::ST_LOAD) ? i_next : j_next;
    assign slot_sum = {1'b0, head_next} + {1'b0, LAST_SLOT} - {1'b0, k_sel};
    assign slot     = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X)
                                            : slot_sum[IDX_W-1:0];

    // shared comparator, ties broken by age order
    assign lt       = (rd_reg < cand_reg) || ((rd_reg == cand_reg) && (j_reg < i_reg));
    assign rank_sum = rank_reg + IDX_W'(lt);
    assign last_j   = (CNT_W'(j_reg) + 1'b1) == fill_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            gate_min_reg   <= gsmf_pkg::GATE_MIN_RST;
            gate_max_reg   <= gsmf_pkg::GATE_MAX_RST;
            fail_limit_reg <= gsmf_pkg::FAIL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gsmf_pkg::CFG_GATE_MIN:   gate_min_reg   <= cfg_data;
                gsmf_pkg::CFG_GATE_MAX:   gate_max_reg   <= cfg_data;
                gsmf_pkg::CFG_FAIL_LIMIT: fail_limit_reg <= cfg_data[gsmf_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // newest sample bypasses the store on the cycle it is written
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[head_reg] <= sample.distance;
        end
        rd_reg <= (store_we && (slot == head_reg)) ? sample.distance : store_mem[slot];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= gsmf_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            streak_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            streak_reg    <= streak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        rank_reg      <= rank_next;
        cand_reg      <= cand_next;
        res_valid_reg <= res_valid_next;
        res_dist_reg  <= res_dist_next;
        out_mv_reg    <= out_mv_next;
        out_dist_reg  <= out_dist_next;
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        streak_next    = streak_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        cand_next      = cand_reg;
        res_valid_next = res_valid_reg;
        res_dist_next  = res_dist_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_mv_next    = out_mv_reg;
        out_dist_next  = out_dist_reg;
        store_we       = 1'b0;

        unique case (state_reg)
            gsmf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_valid_next = 1'b0;
                    res_dist_next  = '0;
                    i_next         = '0;
                    state_next     = gsmf_pkg::ST_DONE;
                    if (good)
                    begin
                        store_we    = 1'b1;
                        head_next   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                        fill_next   = (fill_reg < DEPTH_C) ? fill_reg + 1'b1 : fill_reg;
                        streak_next = '0;
                        if (fill_next >= MIN_C)
                        begin
                            state_next = gsmf_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        streak_next = streak_inc;
                        if (streak_inc >= fail_limit_reg)
                        begin
                            fill_next = '0;
                        end
                        else if (fill_reg >= MIN_C)
                        begin
                            state_next = gsmf_pkg::ST_LOAD;
                        end
                    end
                end
            end
            gsmf_pkg::ST_LOAD:
            begin
                cand_next  = rd_reg;
                j_next     = '0;
                rank_next  = '0;
                state_next = gsmf_pkg::ST_SCAN;
            end
            gsmf_pkg::ST_SCAN:
            begin
                if (last_j)
                begin
                    if (CNT_W'(rank_sum) == (fill_reg >> 1))
                    begin
                        res_valid_next = 1'b1;
                        res_dist_next  = cand_reg;
                        state_next     = gsmf_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = gsmf_pkg::ST_LOAD;
                    end
                end
                else
                begin
                    j_next    = j_reg + 1'b1;
                    rank_next = rank_sum;
                end
            end
            gsmf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mv_next    = res_valid_reg;
                    out_dist_next  = res_dist_reg;
                    state_next     = gsmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/gsmf_checker.sv]
module gsmf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        median_valid,
    input logic [gsmf_pkg::DIST_W-1:0] median_distance
);

    // no median means a zero distance field
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !median_valid) |-> (median_distance == '0))
        else $error("invalid result with nonzero distance");

    // a median only ever comes from gated nonzero samples
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && median_valid) |-> (median_distance != '0))
        else $error("valid median of zero");

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(median_valid) && $stable(median_distance)))
        else $error("stalled result changed");

endmodule

bind gated_sliding_median_filter_top gsmf_checker u_gsmf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .median_valid    (result.median_valid),
    .median_distance (result.median_distance)
);
